// ===== rtl/mrw_pkg.sv =====
`default_nettype none
package mrw_pkg;
  localparam int unsigned NUM_WIDTH_DEF = 31;
endpackage
`default_nettype wire

// ===== rtl/mrw_modmul.sv =====
`default_nettype none
module mrw_modmul #(
  parameter int unsigned NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [NUM_WIDTH-1:0] op_a,
  input  wire logic [NUM_WIDTH-1:0] op_b,
  input  wire logic [NUM_WIDTH-1:0] modulus,
  output logic                      busy,
  output logic                      done,
  output logic [NUM_WIDTH-1:0]      prod
);
  localparam int unsigned CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] acc_r, acc_nxt;
  logic [NUM_WIDTH-1:0] a_r;
  logic [NUM_WIDTH-1:0] b_r;
  logic [NUM_WIDTH-1:0] m_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [NUM_WIDTH+1:0] dbl, dsub, add, asub;
  logic [NUM_WIDTH-1:0] dred;

  always_comb begin
    dbl  = {1'b0, acc_r, 1'b0};
    dsub = dbl - {2'b00, m_r};
    dred = dsub[NUM_WIDTH+1] ? dbl[NUM_WIDTH-1:0] : dsub[NUM_WIDTH-1:0];
    add  = {2'b00, dred} + (b_r[NUM_WIDTH-1] ? {2'b00, a_r} : '0);
    asub = add - {2'b00, m_r};
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      acc_nxt = asub[NUM_WIDTH+1] ? add[NUM_WIDTH-1:0] : asub[NUM_WIDTH-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      acc_nxt  = '0;
      cnt_nxt  = CW'(NUM_WIDTH);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    if (!busy_r && start) begin
      a_r <= op_a;
      b_r <= op_b;
      m_r <= modulus;
    end else if (busy_r) begin
      b_r <= {b_r[NUM_WIDTH-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> busy_r) else $error("start not taken");
  a_res_lt_mod: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < m_r)) else $error("product not reduced");
endmodule
`default_nettype wire

// ===== rtl/miller_rabin_witness_round.sv =====
// Miller-Rabin witness round.
// Input channel: drive in_candidate and in_base with start high; the beat
// is taken at a rising edge with start high and busy low. busy stays high
// while the round runs; no further beat is taken then.
// Result channel: out_valid is high for exactly one cycle with
// out_is_witness; the receiver cannot stall, so the result must be caught
// in that cycle.
// Products: every modular product goes through one shared shift-and-add
// modular multiplier. The base reduction takes one product (1 * a), the
// exponentiation one squaring per exponent bit (NUM_WIDTH bits scanned)
// plus one multiply per set bit, and up to NUM_WIDTH - 1 squarings follow;
// multiplies and final squarings together stay within NUM_WIDTH.
// Candidates below three skip the multiplier and go straight to S_DONE.
// Throughput: one round at a time; the next beat may be taken in the
// cycle that carries the result.
// Reset: synchronous, active low; clears the sequencer and the multiplier
// control, drops any round in progress and leaves busy low.
`default_nettype none
module miller_rabin_witness_round #(
  parameter int unsigned NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [NUM_WIDTH-1:0] in_candidate,
  input  wire logic [NUM_WIDTH-1:0] in_base,
  output logic                      out_valid,
  output logic                      out_is_witness
);
  localparam int unsigned CW = $clog2(NUM_WIDTH + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RED   = 8'b0000_0010,
    S_SQ    = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_LSQ   = 8'b0010_0000,
    S_LCHK  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t               st_r, st_nxt;
  logic [NUM_WIDTH-1:0] n_r, a_r, u_r, x_r, b_r;
  logic [CW-1:0]        t_r, i_r, k_r;
  logic                 res_r, res_nxt;
  logic                 wait_r, wait_nxt;
  logic                 valid_r, valid_nxt;
  logic                 mm_start;
  logic                 mm_busy;
  logic                 mm_done;
  logic [NUM_WIDTH-1:0] mm_a, mm_b, mm_p;
  logic [NUM_WIDTH-1:0] nm1;
  logic [NUM_WIDTH-1:0] one;
  logic [CW-1:0]        tz;
  logic [NUM_WIDTH-1:0] in_nm1;

  assign one = NUM_WIDTH'(1);
  assign nm1 = n_r - one;
  assign in_nm1 = in_candidate - one;

  always_comb begin
    tz = '0;
    for (int j = NUM_WIDTH - 1; j >= 0; j--) begin
      if (in_nm1[j]) tz = CW'(j);
    end
  end

  mrw_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_mm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (n_r),
    .busy    (mm_busy),
    .done    (mm_done),
    .prod    (mm_p)
  );

  always_comb begin
    st_nxt    = st_r;
    res_nxt   = res_r;
    wait_nxt  = wait_r;
    valid_nxt = 1'b0;
    mm_start  = 1'b0;
    mm_a      = x_r;
    mm_b      = x_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          if (in_candidate < NUM_WIDTH'(3)) begin
            res_nxt = 1'b0;
            st_nxt  = S_DONE;
          end else begin
            st_nxt   = S_RED;
            wait_nxt = 1'b0;
          end
        end
      end
      S_RED: begin
        mm_a = one;
        mm_b = a_r;
        if (!wait_r) begin
          mm_start = 1'b1;
          wait_nxt = 1'b1;
        end else if (mm_done) begin
          wait_nxt = 1'b0;
          st_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        if (!wait_r) begin
          mm_start = 1'b1;
          wait_nxt = 1'b1;
        end else if (mm_done) begin
          wait_nxt = 1'b0;
          st_nxt   = u_r[NUM_WIDTH-1] ? S_MUL : S_CHK;
        end
      end
      S_MUL: begin
        mm_b = b_r;
        if (!wait_r) begin
          mm_start = 1'b1;
          wait_nxt = 1'b1;
        end else if (mm_done) begin
          wait_nxt = 1'b0;
          st_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (k_r != '0) begin
          st_nxt = S_SQ;
        end else if (x_r == one) begin
          res_nxt = 1'b0;
          st_nxt  = S_DONE;
        end else begin
          st_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        if (i_r == t_r) begin
          res_nxt = 1'b1;
          st_nxt  = S_DONE;
        end else if (x_r == nm1) begin
          res_nxt = 1'b0;
          st_nxt  = S_DONE;
        end else if (x_r == one) begin
          res_nxt = 1'b1;
          st_nxt  = S_DONE;
        end else begin
          st_nxt = S_LSQ;
        end
      end
      S_LSQ: begin
        if (!wait_r) begin
          mm_start = 1'b1;
          wait_nxt = 1'b1;
        end else if (mm_done) begin
          wait_nxt = 1'b0;
          st_nxt   = S_LCHK;
        end
      end
      S_DONE: begin
        valid_nxt = 1'b1;
        st_nxt    = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      wait_r  <= 1'b0;
      valid_r <= 1'b0;
      res_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      wait_r  <= wait_nxt;
      valid_r <= valid_nxt;
      res_r   <= res_nxt;
    end
    unique case (st_r)
      S_IDLE: begin
        n_r <= in_candidate;
        a_r <= in_base;
        u_r <= in_nm1 >> tz;
        t_r <= tz;
        x_r <= one;
        i_r <= '0;
        k_r <= CW'(NUM_WIDTH - 1);
      end
      S_RED: begin
        if (wait_r && mm_done) b_r <= mm_p;
      end
      S_SQ: begin
        if (wait_r && mm_done) x_r <= mm_p;
      end
      S_MUL: begin
        if (wait_r && mm_done) x_r <= mm_p;
      end
      S_CHK: begin
        u_r <= {u_r[NUM_WIDTH-2:0], 1'b0};
        if (k_r != '0) k_r <= k_r - 1'b1;
      end
      S_LSQ: begin
        if (wait_r && mm_done) begin
          x_r <= mm_p;
          i_r <= i_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy           = (st_r != S_IDLE);
  assign out_valid      = valid_r;
  assign out_is_witness = res_r;

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r) else $error("result strobe held");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (st_r == S_IDLE)) else $error("result outside idle");
  a_mm_start: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> !mm_busy) else $error("multiplier restarted while busy");
  a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LCHK) |-> (i_r <= t_r)) else $error("squaring count overrun");
endmodule
`default_nettype wire

// ===== sim/witness_checker.sv =====
`timescale 1ns / 100ps
module witness_checker #(
  parameter int unsigned NUM_WIDTH = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [NUM_WIDTH-1:0] in_candidate,
  input  wire logic [NUM_WIDTH-1:0] in_base,
  input  wire logic                 out_valid,
  input  wire logic                 out_is_witness,
  output int                        fail_count,
  output int                        pending
);
  bit verdict_q[$];

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x * y) % m;
  endfunction

  function automatic bit witness_of(logic [NUM_WIDTH-1:0] cand, logic [NUM_WIDTH-1:0] bse);
    logic [63:0] n, u, x, b, acc;
    int t;
    n = 64'(cand);
    if (n < 3) return 1'b0;
    u = n - 64'd1;
    t = 0;
    while (u[0] == 1'b0) begin
      u = u >> 1;
      t++;
    end
    b = 64'(bse) % n;
    acc = 64'd1;
    while (u != 0) begin
      if (u[0]) acc = mulmod(acc, b, n);
      b = mulmod(b, b, n);
      u = u >> 1;
    end
    x = acc;
    if (x == 1) return 1'b0;
    for (int i = 0; i < t; i++) begin
      if (x == n - 1) return 1'b0;
      if (x == 1) return 1'b1;
      x = mulmod(x, x, n);
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    bit exp_v;
    if (!rst_n) begin
      fail_count = 0;
      verdict_q.delete();
    end else begin
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual is_witness=%0b",
                   $time, out_is_witness);
          fail_count++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (exp_v !== out_is_witness) begin
            $display("%0t: is_witness mismatch, expected %0b, actual %0b",
                     $time, exp_v, out_is_witness);
            fail_count++;
          end
        end
      end
      if (start && !busy) verdict_q.push_back(witness_of(in_candidate, in_base));
    end
    pending = verdict_q.size();
  end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  localparam int unsigned NW = mrw_pkg::NUM_WIDTH_DEF;
  localparam longint LIMIT = 2000000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [NW-1:0] in_candidate = '0;
  logic [NW-1:0] in_base = '0;
  logic          out_valid;
  logic          out_is_witness;
  int            fail_count;
  int            pending;
  longint        cycles = 0;

  always #1 clk = ~clk;

  miller_rabin_witness_round #(.NUM_WIDTH(NW)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_candidate(in_candidate), .in_base(in_base),
    .out_valid(out_valid), .out_is_witness(out_is_witness)
  );

  witness_checker #(.NUM_WIDTH(NW)) u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_candidate(in_candidate), .in_base(in_base),
    .out_valid(out_valid), .out_is_witness(out_is_witness),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_beat(logic [NW-1:0] cand, logic [NW-1:0] bse, bit quiet);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      in_candidate <= NW'($urandom());
      in_base <= NW'($urandom());
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_candidate <= cand;
    in_base <= bse;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [NW-1:0] rand_num();
    unique case ($urandom_range(0, 4))
      0: return NW'($urandom_range(0, 255));
      1: return NW'({$urandom()} | (32'd1 << (NW - 1)));
      2: return NW'($urandom_range(3, 65535) | 1);
      default: return NW'($urandom());
    endcase
  endfunction

  initial begin
    logic [NW-1:0] c;
    logic [NW-1:0] all1;
    all1 = '1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_beat(NW'(3), NW'(2), 1'b0);
    send_beat(NW'(0), NW'(5), 1'b0);
    send_beat(NW'(1), NW'(5), 1'b0);
    send_beat(NW'(2), NW'(5), 1'b0);
    send_beat(all1, NW'(2), 1'b0);
    send_beat(all1, all1, 1'b0);
    send_beat(all1 - NW'(1), all1, 1'b0);
    send_beat(NW'(561), NW'(2), 1'b0);
    send_beat(NW'(561), NW'(50), 1'b0);
    send_beat(NW'(2047), NW'(2), 1'b0);
    send_beat(NW'(341), NW'(2), 1'b0);
    send_beat(NW'(100), NW'(3), 1'b0);
    send_beat(NW'(97), NW'(0), 1'b0);
    send_beat(NW'(97), NW'(97 * 5), 1'b0);
    send_beat(NW'(97), NW'(96), 1'b0);
    send_beat(NW'(97), NW'(1), 1'b0);
    send_beat(NW'(1105), NW'(1104), 1'b0);
    send_beat(NW'(25326001), NW'(2), 1'b0);
    send_beat(NW'(32'd3215031751), NW'(2), 1'b0);
    send_beat(all1 ^ NW'(1), NW'(0), 1'b0);
    for (int i = 0; i < 120; i++) begin
      c = rand_num();
      if ($urandom_range(0, 9) != 0 && c < NW'(3)) c = c + NW'(3);
      send_beat(c, rand_num(), i > 95);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/mrw_pkg.sv
rtl/mrw_modmul.sv
rtl/miller_rabin_witness_round.sv
sim/witness_checker.sv
sim/testbench.sv
